// ----- rtl/fsesl_pkg.sv -----
// Package for the frame sequencer, envelope, sweep and length unit.
// Holds item types, step thresholds, length and noise tables. No dependencies.
package fsesl_pkg;

   typedef enum logic [1:0] {
      MODE_WRITE   = 2'd0,
      MODE_READ    = 2'd1,
      MODE_ADVANCE = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   localparam logic [4:0] OFF_STATUS = 5'd21;
   localparam logic [4:0] OFF_FRAME  = 5'd23;

   localparam logic [15:0] STEP1_CYCLES = 16'd7457;
   localparam logic [15:0] STEP2_CYCLES = 16'd14912;
   localparam logic [15:0] STEP3_CYCLES = 16'd22371;
   localparam logic [15:0] STEP4_CYCLES = 16'd29828;
   localparam logic [15:0] STEP5_CYCLES = 16'd37281;

   typedef struct packed {
      logic [1:0] mode;
      logic [4:0] reg_offset;
      logic [7:0] write_data;
      logic [4:0] cycle_count;
   } req_type;

   typedef struct packed {
      logic        irq_pulse;
      logic [7:0]  status_byte;
      logic [10:0] pulse1_period;
      logic [3:0]  pulse1_volume;
      logic        pulse1_sounding;
      logic [10:0] pulse2_period;
      logic [3:0]  pulse2_volume;
      logic        pulse2_sounding;
      logic [10:0] triangle_period;
      logic        triangle_sounding;
      logic [8:0]  noise_period;
      logic [3:0]  noise_volume;
   } rsp_type;

   typedef struct packed {
      logic [3:0] divider;
      logic [3:0] counter;
      logic [3:0] level;
      logic       start;
      logic       halt;
      logic       constant;
   } env_type;

   typedef struct packed {
      logic       enabled;
      logic       negate;
      logic       reload;
      logic [3:0] period;
      logic [3:0] counter;
      logic [2:0] shift;
   } sweep_type;

   function automatic logic [7:0] length_lookup(input logic [4:0] i);
      case (i)
         5'd0: length_lookup = 8'h0A;  5'd1: length_lookup = 8'hFE;
         5'd2: length_lookup = 8'h14;  5'd3: length_lookup = 8'h02;
         5'd4: length_lookup = 8'h28;  5'd5: length_lookup = 8'h04;
         5'd6: length_lookup = 8'h50;  5'd7: length_lookup = 8'h06;
         5'd8: length_lookup = 8'hA0;  5'd9: length_lookup = 8'h08;
         5'd10: length_lookup = 8'h3C; 5'd11: length_lookup = 8'h0A;
         5'd12: length_lookup = 8'h0E; 5'd13: length_lookup = 8'h0C;
         5'd14: length_lookup = 8'h1A; 5'd15: length_lookup = 8'h0E;
         5'd16: length_lookup = 8'h0C; 5'd17: length_lookup = 8'h10;
         5'd18: length_lookup = 8'h18; 5'd19: length_lookup = 8'h12;
         5'd20: length_lookup = 8'h30; 5'd21: length_lookup = 8'h14;
         5'd22: length_lookup = 8'h60; 5'd23: length_lookup = 8'h16;
         5'd24: length_lookup = 8'hC0; 5'd25: length_lookup = 8'h18;
         5'd26: length_lookup = 8'h48; 5'd27: length_lookup = 8'h1A;
         5'd28: length_lookup = 8'h10; 5'd29: length_lookup = 8'h1C;
         5'd30: length_lookup = 8'h20; default: length_lookup = 8'h1E;
      endcase
   endfunction

   function automatic logic [8:0] noise_lookup(input logic [3:0] i);
      case (i)
         4'd0: noise_lookup = 9'h1AC;  4'd1: noise_lookup = 9'h17C;
         4'd2: noise_lookup = 9'h154;  4'd3: noise_lookup = 9'h140;
         4'd4: noise_lookup = 9'h11E;  4'd5: noise_lookup = 9'h0FE;
         4'd6: noise_lookup = 9'h0E2;  4'd7: noise_lookup = 9'h0D6;
         4'd8: noise_lookup = 9'h0BE;  4'd9: noise_lookup = 9'h0A0;
         4'd10: noise_lookup = 9'h08E; 4'd11: noise_lookup = 9'h080;
         4'd12: noise_lookup = 9'h06A; 4'd13: noise_lookup = 9'h054;
         4'd14: noise_lookup = 9'h048; default: noise_lookup = 9'h036;
      endcase
   endfunction

endpackage

// ----- rtl/fsesl_stream_if.sv -----
// Valid/ready channel carrying one packed beat.
// Payload type is given by the instantiating code; no dependencies.
interface fsesl_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/fsesl_core.sv -----
// Single-pass update of all sequencer and channel state for one beat.
// Depends on fsesl_pkg.
module fsesl_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  fsesl_pkg::req_type req,
   output fsesl_pkg::rsp_type rsp
);
   import fsesl_pkg::*;

   logic [15:0] frame_cycles_ff, frame_cycles_in;
   logic [2:0]  countdown_ff, countdown_in;
   logic [2:0]  sub_ff, sub_in;
   logic [15:0] thresh_ff, thresh_in;
   logic        five_ff, five_in, inhibit_ff, inhibit_in, irqf_ff, irqf_in;
   logic [10:0] wave_ff [2], wave_in [2];
   sweep_type   sweep_ff [2], sweep_in [2];
   logic [7:0]  len_ff [4], len_in [4];
   logic [3:0]  dis_ff, dis_in;
   env_type     env_ff [3], env_in [3];
   logic [3:0]  vol_ff [3], vol_in [3];
   logic [6:0]  lin_ff, lin_in, trel_ff, trel_in;
   logic [10:0] twave_ff, twave_in;
   logic        thalt_ff, thalt_in, treload_ff, treload_in;
   logic [8:0]  noise_ff, noise_in;

   logic        irq;
   logic [7:0]  status;
   logic        qclk, hclk;
   logic [16:0] fc_sum;
   logic [15:0] fc_adv;
   logic [2:0]  sub_next;
   logic [11:0] sw_w [2];
   logic [11:0] sw_d;
   logic [7:0]  v;

   always_comb begin
      frame_cycles_in = frame_cycles_ff;  countdown_in = countdown_ff;
      sub_in = sub_ff;  thresh_in = thresh_ff;  five_in = five_ff;
      inhibit_in = inhibit_ff;  irqf_in = irqf_ff;
      wave_in = wave_ff;  sweep_in = sweep_ff;  len_in = len_ff;
      dis_in = dis_ff;  env_in = env_ff;  vol_in = vol_ff;
      lin_in = lin_ff;  trel_in = trel_ff;  twave_in = twave_ff;
      thalt_in = thalt_ff;  treload_in = treload_ff;  noise_in = noise_ff;
      irq = 1'b0;  status = 8'd0;  qclk = 1'b0;  hclk = 1'b0;
      fc_sum = 17'd0;  fc_adv = 16'd0;  sub_next = 3'd0;  sw_d = 12'd0;
      sw_w[0] = 12'd0;  sw_w[1] = 12'd0;
      v = req.write_data;

      case (mode_type'(req.mode))
         MODE_WRITE: begin
            if (req.reg_offset < 5'd8) begin
               for (int c = 0; c < 2; c++) begin
                  if (req.reg_offset[2] == c[0]) begin
                     case (req.reg_offset[1:0])
                        2'd0: begin
                           env_in[c].halt = v[5];
                           env_in[c].constant = v[4];
                           env_in[c].divider = v[3:0];
                        end
                        2'd1: begin
                           sweep_in[c].enabled = v[7];
                           sweep_in[c].negate = v[3];
                           sweep_in[c].period = {1'b0, v[6:4]} + 4'd1;
                           sweep_in[c].shift = v[2:0];
                           sweep_in[c].reload = 1'b1;
                        end
                        2'd2: wave_in[c] = {wave_ff[c][10:8], v};
                        default: begin
                           wave_in[c] = {v[2:0], wave_ff[c][7:0]};
                           env_in[c].start = 1'b1;
                           if (!dis_ff[c]) len_in[c] = length_lookup(v[7:3]);
                        end
                     endcase
                  end
               end
            end else begin
               case (req.reg_offset)
                  5'd8: begin
                     thalt_in = v[7];
                     trel_in = v[6:0];
                  end
                  5'd10: twave_in = {twave_ff[10:8], v};
                  5'd11: begin
                     twave_in = {v[2:0], twave_ff[7:0]};
                     treload_in = 1'b1;
                     if (!dis_ff[2]) len_in[2] = length_lookup(v[7:3]);
                  end
                  5'd12: begin
                     env_in[2].halt = v[5];
                     env_in[2].constant = v[4];
                     env_in[2].divider = v[3:0];
                  end
                  5'd14: noise_in = noise_lookup(v[3:0]);
                  5'd15: begin
                     if (!dis_ff[3]) len_in[3] = length_lookup(v[7:3]);
                     env_in[2].start = 1'b1;
                  end
                  OFF_STATUS: begin
                     for (int i = 0; i < 4; i++) begin
                        dis_in[i] = !v[i];
                        if (!v[i]) len_in[i] = 8'd0;
                     end
                  end
                  OFF_FRAME: begin
                     inhibit_in = v[6];
                     if (v[6]) irqf_in = 1'b0;
                     five_in = v[7];
                     hclk = v[7];
                     countdown_in = frame_cycles_ff[0] ? 3'd4 : 3'd3;
                  end
                  default: ;
               endcase
            end
         end
         MODE_READ: begin
            if (req.reg_offset == OFF_STATUS) begin
               for (int i = 0; i < 4; i++) status[i] = (len_ff[i] != 8'd0);
               status[6] = irqf_ff;
               irqf_in = 1'b0;
            end
         end
         MODE_ADVANCE: begin
            if (countdown_ff != 3'd0 && req.cycle_count >= {2'b00, countdown_ff}) begin
               sub_in = 3'd0;
               thresh_in = STEP1_CYCLES;
               fc_sum = {12'd0, req.cycle_count - {2'b00, countdown_ff}};
               countdown_in = 3'd0;
            end else begin
               if (countdown_ff != 3'd0)
                  countdown_in = countdown_ff - req.cycle_count[2:0];
               fc_sum = {1'b0, frame_cycles_ff} + {12'd0, req.cycle_count};
            end
            fc_adv = fc_sum[16] ? 16'hFFFF : fc_sum[15:0];
            frame_cycles_in = fc_adv;
            if (fc_adv >= thresh_in) begin
               sub_next = sub_in + 3'd1;
               if (sub_next <= 3'd3) begin
                  sub_in = sub_next;
                  case (sub_next)
                     3'd1: begin thresh_in = STEP2_CYCLES; qclk = 1'b1; end
                     3'd2: begin thresh_in = STEP3_CYCLES; hclk = 1'b1; end
                     default: begin
                        thresh_in = five_ff ? STEP5_CYCLES : STEP4_CYCLES;
                        qclk = 1'b1;
                     end
                  endcase
               end else begin
                  if (!five_ff && !inhibit_ff) begin
                     irq = !irqf_ff;
                     irqf_in = 1'b1;
                  end
                  hclk = 1'b1;
                  sub_in = 3'd0;
                  thresh_in = STEP1_CYCLES;
                  if (five_ff)
                     frame_cycles_in = (fc_adv >= STEP5_CYCLES) ? fc_adv - STEP5_CYCLES : 16'd0;
                  else
                     frame_cycles_in = (fc_adv >= STEP4_CYCLES) ? fc_adv - STEP4_CYCLES : 16'd0;
               end
            end
         end
         default: ;
      endcase

      if (qclk || hclk) begin
         for (int e = 0; e < 3; e++) begin
            if (env_in[e].start) begin
               env_in[e].level = 4'd15;
               env_in[e].counter = env_in[e].divider;
               env_in[e].start = 1'b0;
            end else if (env_in[e].counter != 4'd0) begin
               env_in[e].counter = env_in[e].counter - 4'd1;
            end else begin
               env_in[e].counter = env_in[e].divider;
               if (env_in[e].level == 4'd0) begin
                  if (env_in[e].halt) env_in[e].level = 4'd15;
               end else begin
                  env_in[e].level = env_in[e].level - 4'd1;
               end
            end
            vol_in[e] = env_in[e].constant ? env_in[e].divider : env_in[e].level;
         end
         if (treload_in) lin_in = trel_in;
         else if (lin_in != 7'd0) lin_in = lin_in - 7'd1;
         if (!thalt_in) treload_in = 1'b0;
      end
      if (hclk) begin
         if (!env_in[0].halt && len_in[0] != 8'd0) len_in[0] = len_in[0] - 8'd1;
         if (!env_in[1].halt && len_in[1] != 8'd0) len_in[1] = len_in[1] - 8'd1;
         if (!env_in[2].halt && len_in[3] != 8'd0) len_in[3] = len_in[3] - 8'd1;
         if (!thalt_in && len_in[2] != 8'd0) len_in[2] = len_in[2] - 8'd1;
         for (int c = 0; c < 2; c++) begin
            if (sweep_in[c].enabled) begin
               if (sweep_in[c].reload) begin
                  sweep_in[c].counter = sweep_in[c].period;
                  sweep_in[c].reload = 1'b0;
               end else if (sweep_in[c].counter != 4'd0) begin
                  sweep_in[c].counter = sweep_in[c].counter - 4'd1;
               end else begin
                  sw_d = {1'b0, wave_in[c] >> sweep_in[c].shift};
                  if (sweep_in[c].negate)
                     sw_w[c] = {1'b0, wave_in[c]} - sw_d - ((c == 0) ? 12'd1 : 12'd0);
                  else
                     sw_w[c] = {1'b0, wave_in[c]} + sw_d;
                  if (sw_w[c][11] || sw_w[c] < 12'd8) wave_in[c] = 11'd0;
                  else wave_in[c] = sw_w[c][10:0];
                  sweep_in[c].counter = sweep_in[c].period;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_cycles_ff <= '0;  countdown_ff <= '0;  sub_ff <= '0;  thresh_ff <= '0;
         five_ff <= 1'b0;  inhibit_ff <= 1'b0;  irqf_ff <= 1'b0;
         wave_ff[0] <= '0;  wave_ff[1] <= '0;  sweep_ff[0] <= '0;  sweep_ff[1] <= '0;
         for (int i = 0; i < 4; i++) len_ff[i] <= '0;
         dis_ff <= '0;
         for (int e = 0; e < 3; e++) begin
            env_ff[e] <= '0;
            vol_ff[e] <= '0;
         end
         lin_ff <= '0;  trel_ff <= '0;  twave_ff <= '0;
         thalt_ff <= 1'b0;  treload_ff <= 1'b0;  noise_ff <= '0;
      end else if (step) begin
         frame_cycles_ff <= frame_cycles_in;  countdown_ff <= countdown_in;
         sub_ff <= sub_in;  thresh_ff <= thresh_in;  five_ff <= five_in;
         inhibit_ff <= inhibit_in;  irqf_ff <= irqf_in;
         wave_ff <= wave_in;  sweep_ff <= sweep_in;  len_ff <= len_in;
         dis_ff <= dis_in;  env_ff <= env_in;  vol_ff <= vol_in;
         lin_ff <= lin_in;  trel_ff <= trel_in;  twave_ff <= twave_in;
         thalt_ff <= thalt_in;  treload_ff <= treload_in;  noise_ff <= noise_in;
      end
   end

   always_comb begin
      rsp.irq_pulse = irq;
      rsp.status_byte = status;
      rsp.pulse1_period = wave_in[0];
      rsp.pulse1_volume = vol_in[0];
      rsp.pulse1_sounding = (wave_in[0] > 11'd2) && (len_in[0] != 8'd0);
      rsp.pulse2_period = wave_in[1];
      rsp.pulse2_volume = vol_in[1];
      rsp.pulse2_sounding = (wave_in[1] > 11'd2) && (len_in[1] != 8'd0);
      rsp.triangle_period = twave_in;
      rsp.triangle_sounding = (twave_in > 11'd2) && (len_in[2] != 8'd0) && (lin_in != 7'd0);
      rsp.noise_period = (len_in[3] != 8'd0) ? noise_in : 9'd0;
      rsp.noise_volume = vol_in[2];
   end

endmodule

// ----- rtl/frame_sequencer_envelope_sweep_length_unit.sv -----
// Top level: input register, single-pass core, result register.
// Depends on fsesl_pkg, fsesl_stream_if and fsesl_core.
//
//   channel   dir   beat
//   req       in    mode, reg_offset, write_data, cycle_count
//   rsp       out   irq_pulse, status_byte, periods, volumes, gates
//
// One beat per cycle while the result register is not stalled; a beat is taken into the
// input register, then the core updates state and loads the result register
// once that register is free. The input register holds while the result register is full
// and stalled. Synchronous reset clears all sequencer and channel state.
module frame_sequencer_envelope_sweep_length_unit (
   input logic clock,
   input logic reset,
   fsesl_stream_if.sink   req,
   fsesl_stream_if.source rsp
);
   import fsesl_pkg::*;

   logic    in_valid_ff, out_valid_ff;
   req_type in_data_ff;
   rsp_type out_data_ff, core_rsp;
   logic    advance;

   assign advance = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   fsesl_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_data_ff),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req.ready) in_valid_ff <= req.valid;
         if (advance) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) in_data_ff <= req.payload;
      if (advance) out_data_ff <= core_rsp;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_data_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp.ready |=> out_valid_ff && $stable(out_data_ff))
      else $error("result dropped under stall");
   a_adv: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result not loaded");
   a_status: assert property (@(posedge clock) disable iff (reset)
      advance && in_data_ff.mode != MODE_READ |-> core_rsp.status_byte == 8'd0)
      else $error("status outside read");

endmodule

// ----- tb/sv/tb_fsesl_checker.sv -----
`timescale 1ns / 1ps
// Checker for the frame sequencer, envelope, sweep and length unit: predicts each
// result beat from the request beats and compares it field by field.
// Depends on fsesl_pkg and fsesl_stream_if.
module tb_fsesl_checker (
   input  logic   clock,
   input  logic   reset,
   fsesl_stream_if req_mon,
   fsesl_stream_if rsp_mon,
   output int     errors,
   output int     pending
);
   import fsesl_pkg::*;

   typedef struct {
      int   linear;
      int   period;
      int   reload_value;
      logic halt;
      logic reload;
   } tri_state_type;

   localparam logic [7:0] LENGTHS [32] = '{
      8'h0A, 8'hFE, 8'h14, 8'h02, 8'h28, 8'h04, 8'h50, 8'h06,
      8'hA0, 8'h08, 8'h3C, 8'h0A, 8'h0E, 8'h0C, 8'h1A, 8'h0E,
      8'h0C, 8'h10, 8'h18, 8'h12, 8'h30, 8'h14, 8'h60, 8'h16,
      8'hC0, 8'h18, 8'h48, 8'h1A, 8'h10, 8'h1C, 8'h20, 8'h1E};
   localparam logic [8:0] NOISE_PERIODS [16] = '{
      9'h1AC, 9'h17C, 9'h154, 9'h140, 9'h11E, 9'h0FE, 9'h0E2, 9'h0D6,
      9'h0BE, 9'h0A0, 9'h08E, 9'h080, 9'h06A, 9'h054, 9'h048, 9'h036};

   int            cyc_count, countdown, step_idx, threshold;
   logic          five_step, inhibit, irq_flag;
   int            pulse_per [2];
   sweep_type     sweep [2];
   int            len [4];
   logic          len_off [4];
   env_type       env [3];
   logic [3:0]    vol [3];
   tri_state_type tri_ch;
   logic [8:0]    noise_per;
   rsp_type       rsp_expected [$];

   function automatic void clear_state();
      cyc_count = 0; countdown = 0; step_idx = 0; threshold = 0;
      five_step = 1'b0; inhibit = 1'b0; irq_flag = 1'b0;
      for (int i = 0; i < 2; i++) begin
         pulse_per[i] = 0;
         sweep[i] = '0;
      end
      for (int i = 0; i < 4; i++) begin
         len[i] = 0;
         len_off[i] = 1'b0;
      end
      for (int i = 0; i < 3; i++) begin
         env[i] = '0;
         vol[i] = '0;
      end
      tri_ch = '{0, 0, 0, 1'b0, 1'b0};
      noise_per = '0;
   endfunction

   function automatic void quarter_tick();
      for (int i = 0; i < 3; i++) begin
         if (env[i].start) begin
            env[i].level = 4'd15;
            env[i].counter = env[i].divider;
            env[i].start = 1'b0;
         end else if (env[i].counter != 4'd0) begin
            env[i].counter = env[i].counter - 4'd1;
         end else begin
            env[i].counter = env[i].divider;
            if (env[i].level == 4'd0) begin
               if (env[i].halt) env[i].level = 4'd15;
            end else begin
               env[i].level = env[i].level - 4'd1;
            end
         end
         vol[i] = env[i].constant ? env[i].divider : env[i].level;
      end
      if (tri_ch.reload) tri_ch.linear = tri_ch.reload_value;
      else if (tri_ch.linear != 0) tri_ch.linear--;
      if (!tri_ch.halt) tri_ch.reload = 1'b0;
   endfunction

   function automatic void sweep_tick(int ch);
      int w;
      if (!sweep[ch].enabled) return;
      if (sweep[ch].reload) begin
         sweep[ch].counter = sweep[ch].period;
         sweep[ch].reload = 1'b0;
      end else if (sweep[ch].counter != 4'd0) begin
         sweep[ch].counter = sweep[ch].counter - 4'd1;
      end else begin
         w = pulse_per[ch];
         if (sweep[ch].negate) begin
            w = w - (w >> sweep[ch].shift);
            if (ch == 0) w--;
         end else begin
            w = w + (w >> sweep[ch].shift);
         end
         if (w < 8 || w > 2047) w = 0;
         pulse_per[ch] = w;
         sweep[ch].counter = sweep[ch].period;
      end
   endfunction

   function automatic void half_tick();
      quarter_tick();
      if (!env[0].halt && len[0] != 0) len[0]--;
      if (!env[1].halt && len[1] != 0) len[1]--;
      if (!env[2].halt && len[3] != 0) len[3]--;
      if (!tri_ch.halt && len[2] != 0) len[2]--;
      sweep_tick(0);
      sweep_tick(1);
   endfunction

   function automatic void load_len(int ch, logic [7:0] v);
      if (!len_off[ch]) len[ch] = LENGTHS[v[7:3]];
   endfunction

   function automatic void set_env(int e, logic [7:0] v);
      env[e].halt = v[5];
      env[e].constant = v[4];
      env[e].divider = v[3:0];
   endfunction

   function automatic void write_reg(logic [4:0] off, logic [7:0] v);
      int ch;
      ch = off[2];
      if (off < 8) begin
         case (off[1:0])
            2'd0: set_env(ch, v);
            2'd1: begin
               sweep[ch].enabled = v[7];
               sweep[ch].negate = v[3];
               sweep[ch].period = {1'b0, v[6:4]} + 4'd1;
               sweep[ch].shift = v[2:0];
               sweep[ch].reload = 1'b1;
            end
            2'd2: pulse_per[ch] = (pulse_per[ch] & 'h700) | v;
            default: begin
               pulse_per[ch] = (pulse_per[ch] & 'hFF) | (int'(v[2:0]) << 8);
               env[ch].start = 1'b1;
               load_len(ch, v);
            end
         endcase
         return;
      end
      case (off)
         5'd8: begin
            tri_ch.halt = v[7];
            tri_ch.reload_value = v[6:0];
         end
         5'd10: tri_ch.period = (tri_ch.period & 'h700) | v;
         5'd11: begin
            tri_ch.period = (tri_ch.period & 'hFF) | (int'(v[2:0]) << 8);
            tri_ch.reload = 1'b1;
            load_len(2, v);
         end
         5'd12: set_env(2, v);
         5'd14: noise_per = NOISE_PERIODS[v[3:0]];
         5'd15: begin
            load_len(3, v);
            env[2].start = 1'b1;
         end
         OFF_STATUS: begin
            for (int i = 0; i < 4; i++) begin
               len_off[i] = !v[i];
               if (len_off[i]) len[i] = 0;
            end
         end
         OFF_FRAME: begin
            inhibit = v[6];
            if (inhibit) irq_flag = 1'b0;
            five_step = v[7];
            if (five_step) half_tick();
            countdown = 3 + (cyc_count & 1);
         end
         default: ;
      endcase
   endfunction

   function automatic logic step_sequence();
      logic irq;
      irq = 1'b0;
      if (step_idx < 3) begin
         step_idx++;
         if (step_idx == 1) begin
            threshold = STEP2_CYCLES;
            quarter_tick();
         end else if (step_idx == 2) begin
            threshold = STEP3_CYCLES;
            half_tick();
         end else begin
            threshold = five_step ? STEP5_CYCLES : STEP4_CYCLES;
            quarter_tick();
         end
         return 1'b0;
      end
      if (!five_step && !inhibit) begin
         irq = !irq_flag;
         irq_flag = 1'b1;
      end
      half_tick();
      step_idx = 0;
      threshold = STEP1_CYCLES;
      cyc_count -= five_step ? STEP5_CYCLES : STEP4_CYCLES;
      if (cyc_count < 0) cyc_count = 0;
      return irq;
   endfunction

   function automatic logic advance(int c);
      if (countdown != 0 && c >= countdown) begin
         step_idx = 0;
         threshold = STEP1_CYCLES;
         cyc_count = c - countdown;
         countdown = 0;
      end else begin
         if (countdown != 0) countdown -= c;
         cyc_count += c;
      end
      if (cyc_count > 'hFFFF) cyc_count = 'hFFFF;
      if (cyc_count < threshold) return 1'b0;
      return step_sequence();
   endfunction

   function automatic rsp_type predict_beat(req_type r);
      rsp_type o;
      o = '0;
      case (mode_type'(r.mode))
         MODE_WRITE: write_reg(r.reg_offset, r.write_data);
         MODE_READ: begin
            if (r.reg_offset == OFF_STATUS) begin
               for (int i = 0; i < 4; i++) o.status_byte[i] = (len[i] != 0);
               o.status_byte[6] = irq_flag;
               irq_flag = 1'b0;
            end
         end
         MODE_ADVANCE: o.irq_pulse = advance(r.cycle_count);
         default: ;
      endcase
      o.pulse1_period = 11'(pulse_per[0]);
      o.pulse1_volume = vol[0];
      o.pulse1_sounding = pulse_per[0] > 2 && len[0] != 0;
      o.pulse2_period = 11'(pulse_per[1]);
      o.pulse2_volume = vol[1];
      o.pulse2_sounding = pulse_per[1] > 2 && len[1] != 0;
      o.triangle_period = 11'(tri_ch.period);
      o.triangle_sounding = tri_ch.period > 2 && len[2] != 0 && tri_ch.linear != 0;
      o.noise_period = (len[3] != 0) ? noise_per : 9'd0;
      o.noise_volume = vol[2];
      return o;
   endfunction

   function automatic void check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type e, a;
      if (reset) begin
         clear_state();
         rsp_expected.delete();
         errors = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            rsp_expected.push_back(predict_beat(req_mon.payload));
         if (rsp_mon.valid && rsp_mon.ready) begin
            a = rsp_mon.payload;
            if (rsp_expected.size() == 0) begin
               $error("result beat with no expected result");
               errors++;
            end else begin
               e = rsp_expected.pop_front();
               check_field("irq_pulse", e.irq_pulse, a.irq_pulse);
               check_field("status_byte", e.status_byte, a.status_byte);
               check_field("pulse1_period", e.pulse1_period, a.pulse1_period);
               check_field("pulse1_volume", e.pulse1_volume, a.pulse1_volume);
               check_field("pulse1_sounding", e.pulse1_sounding, a.pulse1_sounding);
               check_field("pulse2_period", e.pulse2_period, a.pulse2_period);
               check_field("pulse2_volume", e.pulse2_volume, a.pulse2_volume);
               check_field("pulse2_sounding", e.pulse2_sounding, a.pulse2_sounding);
               check_field("triangle_period", e.triangle_period, a.triangle_period);
               check_field("triangle_sounding", e.triangle_sounding,
                           a.triangle_sounding);
               check_field("noise_period", e.noise_period, a.noise_period);
               check_field("noise_volume", e.noise_volume, a.noise_volume);
            end
         end
      end
      pending = rsp_expected.size();
   end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, request and result stimulus, verdict.
// Depends on fsesl_pkg, fsesl_stream_if, tb_fsesl_checker and the unit itself.
module tb;
   import fsesl_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors, pending;
   logic steady = 1'b0;

   fsesl_stream_if #(.payload_type(req_type)) req_bus ();
   fsesl_stream_if #(.payload_type(rsp_type)) rsp_bus ();

   frame_sequencer_envelope_sweep_length_unit i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus.sink),
      .rsp   (rsp_bus.source)
   );

   tb_fsesl_checker i_checker (
      .clock   (clock),
      .reset   (reset),
      .req_mon (req_bus),
      .rsp_mon (rsp_bus),
      .errors  (errors),
      .pending (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int draw_gap();
      if (steady || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 18);
   endfunction

   task automatic send_beat(req_type r);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.payload <= r;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic send_fields(mode_type m, int off, int data, int cyc);
      req_type r;
      r.mode = m;
      r.reg_offset = 5'(off);
      r.write_data = 8'(data);
      r.cycle_count = 5'(cyc);
      send_beat(r);
   endtask

   // Random beat; frame_ok allows frame counter writes, adv_pct weights time advances.
   function automatic req_type random_beat(logic frame_ok, int adv_pct);
      req_type r;
      int      pick;
      int      offs [14] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 10, 11, 12, 14, 15};
      r.reg_offset = 5'($urandom);
      r.write_data = 8'($urandom);
      r.cycle_count = 5'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < adv_pct) begin
         r.mode = MODE_ADVANCE;
         if ($urandom_range(0, 29) != 0) r.cycle_count = 5'($urandom_range(24, 31));
      end else if (pick < adv_pct + 6) begin
         r.mode = MODE_READ;
         if ($urandom_range(0, 3) != 0) r.reg_offset = OFF_STATUS;
      end else if (pick < adv_pct + 8) begin
         r.mode = MODE_NONE;
      end else begin
         r.mode = MODE_WRITE;
         pick = $urandom_range(0, 19);
         if (pick < 15) r.reg_offset = 5'(offs[$urandom_range(0, 13)]);
         else if (pick < 17) r.reg_offset = OFF_STATUS;
         else if (pick < 18 && frame_ok) r.reg_offset = OFF_FRAME;
         else if (r.reg_offset == OFF_FRAME && !frame_ok) r.reg_offset = 5'd9;
         if (r.reg_offset == OFF_STATUS && $urandom_range(0, 1)) r.write_data[3:0] = 4'hF;
      end
      return r;
   endfunction

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         int gap;
         gap = draw_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, every mode, unused offsets, odd reads
      send_fields(MODE_ADVANCE, 0, 0, 0);
      send_fields(MODE_WRITE, OFF_STATUS, 8'hFF, 0);
      send_fields(MODE_WRITE, 0, 8'hFF, 0);
      send_fields(MODE_WRITE, 1, 8'hFF, 0);
      send_fields(MODE_WRITE, 2, 8'hFF, 0);
      send_fields(MODE_WRITE, 3, 8'hFF, 0);
      send_fields(MODE_WRITE, 4, 8'h00, 0);
      send_fields(MODE_WRITE, 5, 8'h80, 0);
      send_fields(MODE_WRITE, 6, 8'h00, 0);
      send_fields(MODE_WRITE, 7, 8'h00, 0);
      send_fields(MODE_WRITE, 8, 8'hFF, 0);
      send_fields(MODE_WRITE, 10, 8'hFF, 0);
      send_fields(MODE_WRITE, 11, 8'hFF, 0);
      send_fields(MODE_WRITE, 12, 8'h1F, 0);
      send_fields(MODE_WRITE, 14, 8'h0F, 0);
      send_fields(MODE_WRITE, 15, 8'hF8, 0);
      send_fields(MODE_WRITE, 31, 8'hFF, 31);
      send_fields(MODE_WRITE, OFF_FRAME, 8'h80, 0);
      send_fields(MODE_ADVANCE, 0, 0, 31);
      send_fields(MODE_WRITE, OFF_FRAME, 8'h40, 0);
      send_fields(MODE_ADVANCE, 0, 0, 2);
      send_fields(MODE_ADVANCE, 0, 0, 31);
      send_fields(MODE_READ, OFF_STATUS, 0, 0);
      send_fields(MODE_READ, 5, 0, 0);
      send_fields(MODE_NONE, 31, 8'hFF, 31);
      send_fields(MODE_WRITE, OFF_FRAME, 8'h00, 0);
      for (int n = 0; n < 75; n++) send_beat(random_beat(1'b1, 45));
      // hold until every result has drained
      req_bus.valid <= 1'b0;
      wait (pending == 0);
      @(posedge clock);
      // long run of advances so the 4-step sequence reaches its IRQ step
      send_fields(MODE_WRITE, OFF_FRAME, 8'h00, 0);
      for (int n = 0; n < 1150; n++) send_beat(random_beat(1'b0, 99));
      steady = 1'b1;
      for (int n = 0; n < 150; n++) send_beat(random_beat(1'b1, 40));
      steady = 1'b0;
      for (int n = 0; n < 150; n++) send_beat(random_beat(1'b1, 60));
      req_bus.valid <= 1'b0;
      wait (pending == 0);
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("Verification failed");
      $finish;
   end

endmodule
